// File: sv/winsorized_mean_engine_macros.svh
// ----------------------------------------------------------------------------
// Winsorized mean engine assertion macros
// Shared helpers for writing clocked checks with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef WINSORIZED_MEAN_ENGINE_MACROS_SVH
`define WINSORIZED_MEAN_ENGINE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WME_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define WME_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/wme_pkg.sv
// ----------------------------------------------------------------------------
// Winsorized mean engine package
// Shared constants, register indexes and configuration types.
// ----------------------------------------------------------------------------
package wme_pkg;

  localparam int MAX_LEN_DEF     = 256;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int OUT_W           = 16;
  localparam int CFG_DATA_W      = 9;
  localparam int CFG_IDX_W       = 2;
  localparam int LEN_CFG_W       = 9;
  localparam int RANK_CFG_W      = 8;
  localparam int QUEUE_DEPTH     = 4;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_RANK      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_RANK     = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [LEN_CFG_W-1:0]  VECTOR_LENGTH_RST = 9'd256;
  localparam logic [RANK_CFG_W-1:0] LOW_RANK_RST      = 8'd0;
  localparam logic [RANK_CFG_W-1:0] HIGH_RANK_RST     = 8'd255;

  typedef struct packed {
    logic [LEN_CFG_W-1:0]  vector_length;
    logic [RANK_CFG_W-1:0] low_rank;
    logic [RANK_CFG_W-1:0] high_rank;
  } wme_cfg_t;

endpackage

// File: sv/wme_front.sv
// ----------------------------------------------------------------------------
// Winsorized mean front end
// Accepts samples, tracks the position in the vector and marks the last one.
// ----------------------------------------------------------------------------
module wme_front
  import wme_pkg::*;
#(
  parameter int MAX_LEN     = MAX_LEN_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int LEN_W      = $clog2(MAX_LEN + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fill_clear,
  input  logic [LEN_W-1:0]              len_eff,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [SAMPLE_BITS:0]          q_data
);

  logic [LEN_W-1:0] fill_r, fill_nxt;
  logic [LEN_W-1:0] base;
  logic [LEN_W-1:0] pos;
  logic             last;

  // Stall whenever the queue towards the back end is full.
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // A sample is the last of its vector once the fill reaches the length.
  always_comb begin
    base     = (fill_r >= len_eff) ? '0 : fill_r;
    pos      = base + LEN_W'(1);
    last     = (pos >= len_eff);
    fill_nxt = fill_r;
    if (q_push) begin
      fill_nxt = last ? '0 : pos;
    end
  end

  assign q_data = {last, in_sample};

  always_ff @(posedge clk) begin
    if (!rst_n || fill_clear) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

endmodule

// File: sv/wme_queue.sv
// ----------------------------------------------------------------------------
// Winsorized mean item queue
// Short FIFO that lets the front and back ends stall independently.
// ----------------------------------------------------------------------------
module wme_queue
  import wme_pkg::*;
#(
  parameter int WIDTH  = SAMPLE_BITS_DEF + 1,
  parameter int DEPTH  = QUEUE_DEPTH,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  // Storage for queued requests.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

// File: sv/wme_div.sv
// ----------------------------------------------------------------------------
// Winsorized mean divider
// Restoring unsigned divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wme_div #(
  parameter int DVD_W   = 26,
  parameter int DSR_W   = 10,
  localparam int CNT_W  = $clog2(DVD_W + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  logic [DVD_W-1:0] dvd_r;
  logic [DSR_W-1:0] dsr_r;
  logic [DSR_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   diff;
  logic             qbit;

  // One restoring step: shift in the next dividend bit and try to subtract.
  always_comb begin
    trial = {rem_r, dvd_r[DVD_W-1]};
    diff  = trial - {1'b0, dsr_r};
    qbit  = (trial >= {1'b0, dsr_r});
  end

  assign done     = done_r;
  assign quotient = dvd_r;

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], qbit};
      rem_r <= qbit ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// File: sv/wme_back.sv
// ----------------------------------------------------------------------------
// Winsorized mean back end
// Insertion sorter, clamped summation, rounding division and result register.
// ----------------------------------------------------------------------------
module wme_back
  import wme_pkg::*;
#(
  parameter int MAX_LEN     = MAX_LEN_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int LEN_W      = $clog2(MAX_LEN + 1),
  localparam int SUM_W      = SAMPLE_BITS + LEN_W,
  localparam int DVD_W      = SUM_W + 1,
  localparam int DSR_W      = LEN_W + 1,
  localparam int EXT_W      = (DVD_W > OUT_W) ? DVD_W : OUT_W
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     fill_clear,
  input  logic [LEN_W-1:0]         len_eff,
  input  logic [LEN_W-1:0]         rank_lo,
  input  logic [LEN_W-1:0]         rank_hi,
  input  logic                     q_empty,
  input  logic [SAMPLE_BITS:0]     q_data,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [OUT_W-1:0]  out_trimmed_mean
);

  `include "winsorized_mean_engine_macros.svh"

  typedef enum logic [5:0] {
    S_FILL  = 6'b000001,
    S_SHIFT = 6'b000010,
    S_MUL   = 6'b000100,
    S_ADD   = 6'b001000,
    S_DIV   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [SAMPLE_BITS-1:0] cells_r [MAX_LEN];
  logic signed [SAMPLE_BITS-1:0] cells_nxt [MAX_LEN];
  logic [MAX_LEN-1:0]            valid_r;
  logic [MAX_LEN-1:0]            lt;

  logic signed [SAMPLE_BITS-1:0] new_sample;
  logic                          new_last;
  logic [LEN_W-1:0]              k_r;
  logic [LEN_W-1:0]              r1_r, r2_r;
  logic signed [SAMPLE_BITS-1:0] s1_r, s2_r;
  logic signed [SUM_W-1:0]       acc_r;
  logic signed [SUM_W-1:0]       p1_r, p2_r;
  logic [LEN_W-1:0]              tail_cnt;
  logic signed [SUM_W-1:0]       sum;
  logic                          neg_r;
  logic [SUM_W-1:0]              mag;
  logic [DVD_W-1:0]              dividend;
  logic                          div_start;
  logic                          div_done;
  logic [DVD_W-1:0]              quot;
  logic signed [DVD_W-1:0]       quot_s_r;
  logic signed [EXT_W-1:0]       quot_ext;
  logic                          out_valid_r;
  logic signed [OUT_W-1:0]       out_mean_r;
  logic                          out_free;

  assign new_sample = q_data[SAMPLE_BITS-1:0];
  assign new_last   = q_data[SAMPLE_BITS];
  assign q_pop      = (state_r == S_FILL) && !q_empty;

  // Each cell compares itself with the incoming sample.
  always_comb begin
    for (int i = 0; i < MAX_LEN; i++) begin
      lt[i] = valid_r[i] && (cells_r[i] <= new_sample);
    end
  end

  // Insert while filling, shift towards cell zero while summing.
  always_comb begin
    for (int i = 0; i < MAX_LEN; i++) begin
      cells_nxt[i] = cells_r[i];
      if (state_r == S_SHIFT) begin
        if (i < MAX_LEN - 1) begin
          cells_nxt[i] = cells_r[(i + 1) % MAX_LEN];
        end
      end else if (q_pop) begin
        if (!lt[i]) begin
          if (i == 0) begin
            cells_nxt[i] = new_sample;
          end else if (lt[(i + MAX_LEN - 1) % MAX_LEN]) begin
            cells_nxt[i] = new_sample;
          end else begin
            cells_nxt[i] = cells_r[(i + MAX_LEN - 1) % MAX_LEN];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_LEN; i++) begin
      cells_r[i] <= cells_nxt[i];
    end
  end

  // Occupied cells form a prefix of the row.
  always_ff @(posedge clk) begin
    if (!rst_n || fill_clear) begin
      valid_r <= '0;
    end else if (q_pop) begin
      valid_r <= new_last ? '0 : {valid_r[MAX_LEN-2:0], 1'b1};
    end
  end

  // Next state.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_FILL:  if (q_pop && new_last) state_nxt = S_SHIFT;
      S_SHIFT: if (k_r == len_eff - LEN_W'(1)) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_ADD;
      S_ADD:   state_nxt = S_DIV;
      S_DIV:   if (div_done) state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_FILL;
      default: state_nxt = S_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || fill_clear) begin
      state_r <= S_FILL;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Walk the sorted values, capture the two boundary values, sum the middle.
  always_ff @(posedge clk) begin
    if (state_r == S_FILL) begin
      k_r   <= '0;
      acc_r <= '0;
      r1_r  <= rank_lo;
      r2_r  <= rank_hi;
    end else if (state_r == S_SHIFT) begin
      k_r <= k_r + LEN_W'(1);
      if (k_r == r1_r) begin
        s1_r <= cells_r[0];
      end
      if (k_r == r2_r) begin
        s2_r <= cells_r[0];
      end
      if ((k_r >= r1_r) && (k_r <= r2_r)) begin
        acc_r <= acc_r + SUM_W'(cells_r[0]);
      end
    end
  end

  // Replicated boundary values below and above the kept ranks.
  assign tail_cnt = len_eff - LEN_W'(1) - r2_r;

  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      p1_r <= $signed({1'b0, r1_r}) * SUM_W'(s1_r);
      p2_r <= $signed({1'b0, tail_cnt}) * SUM_W'(s2_r);
    end
  end

  // Round half away from zero: (2|sum| + len) / (2 len).
  always_comb begin
    sum      = acc_r + p1_r + p2_r;
    mag      = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    dividend = {mag, 1'b0} + DVD_W'(len_eff);
  end

  assign div_start = (state_r == S_ADD);

  always_ff @(posedge clk) begin
    if (div_start) begin
      neg_r <= sum[SUM_W-1];
    end
  end

  wme_div #(
    .DVD_W (DVD_W),
    .DSR_W (DSR_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  ({len_eff, 1'b0}),
    .done     (div_done),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (div_done) begin
      quot_s_r <= neg_r ? -$signed(quot) : $signed(quot);
    end
  end

  assign quot_ext = EXT_W'(quot_s_r);

  // Result register.
  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && out_free) begin
      out_mean_r <= quot_ext[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_trimmed_mean = out_mean_r;

  // The walk never runs past the vector length.
  `WME_ASSERT_NOW(a_walk_in_range, state_r == S_SHIFT, k_r < len_eff,
    "sorted walk ran past the vector length")
  // The divider only reports completion while the back end waits for it.
  `WME_ASSERT_NOW(a_div_done_in_div, div_done, state_r == S_DIV,
    "divider finished outside the division state")
  // Queue requests are taken only while filling the sorter.
  `WME_ASSERT_NOW(a_pop_only_fill, q_pop, state_r == S_FILL && !q_empty,
    "queue popped outside the fill state")
  // A finished division is handed on in the following cycle.
  `WME_ASSERT_NEXT(a_div_then_done, state_r == S_DIV && div_done, state_r == S_DONE,
    "division result not moved to the done state")

endmodule

// File: sv/winsorized_mean_engine.sv
// ----------------------------------------------------------------------------
// Winsorized mean engine
// Collects vectors of signed samples and returns their winsorized mean.
// ----------------------------------------------------------------------------
// Each sample is accepted into a four-entry queue and inserted into a row of
// sorting cells, one per cycle while the back end is filling. After the last
// sample of a vector the back end walks the sorted row, forms the clamped sum
// in a multiply step and an add step, runs a bit-serial divider and loads the
// result register; up to four samples of the next vector are queued while the
// back end is busy, after which the input stalls. Writing vector_length
// restarts collection.
module winsorized_mean_engine
  import wme_pkg::*;
#(
  parameter int MAX_LEN     = MAX_LEN_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [OUT_W-1:0]       out_trimmed_mean
);

  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int CMP_W = (LEN_W > LEN_CFG_W) ? LEN_W : LEN_CFG_W;

  wme_cfg_t         cfg_r;
  logic             cfg_we;
  logic             fill_clear;
  logic [CMP_W-1:0] vl_ext, len_ext, lo_ext, hi_ext, lo_c, hi_c;
  logic [LEN_W-1:0] len_eff, rank_lo, rank_hi;

  logic               q_push, q_pop, q_full, q_empty;
  logic [SAMPLE_BITS:0] q_wdata, q_rdata;

  // Configuration registers.
  assign cfg_ready  = 1'b1;
  assign cfg_we     = cfg_valid && cfg_ready;
  assign fill_clear = cfg_we && (cfg_index == REG_VECTOR_LENGTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.vector_length <= VECTOR_LENGTH_RST;
      cfg_r.low_rank      <= LOW_RANK_RST;
      cfg_r.high_rank     <= HIGH_RANK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VECTOR_LENGTH: cfg_r.vector_length <= cfg_data[LEN_CFG_W-1:0];
        REG_LOW_RANK:      cfg_r.low_rank      <= cfg_data[RANK_CFG_W-1:0];
        REG_HIGH_RANK:     cfg_r.high_rank     <= cfg_data[RANK_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective length and clamped ranks.
  always_comb begin
    vl_ext = CMP_W'(cfg_r.vector_length);
    if (vl_ext == '0) begin
      len_ext = CMP_W'(1);
    end else if (vl_ext > CMP_W'(MAX_LEN)) begin
      len_ext = CMP_W'(MAX_LEN);
    end else begin
      len_ext = vl_ext;
    end
    lo_ext = CMP_W'(cfg_r.low_rank);
    hi_ext = CMP_W'(cfg_r.high_rank);
    lo_c   = (lo_ext >= len_ext) ? len_ext - CMP_W'(1) : lo_ext;
    hi_c   = (hi_ext >= len_ext) ? len_ext - CMP_W'(1) : hi_ext;
    if (hi_c < lo_c) begin
      hi_c = lo_c;
    end
  end

  assign len_eff = len_ext[LEN_W-1:0];
  assign rank_lo = lo_c[LEN_W-1:0];
  assign rank_hi = hi_c[LEN_W-1:0];

  wme_front #(
    .MAX_LEN     (MAX_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .fill_clear (fill_clear),
    .len_eff    (len_eff),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_sample  (in_sample),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  wme_queue #(
    .WIDTH (SAMPLE_BITS + 1),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  wme_back #(
    .MAX_LEN     (MAX_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .fill_clear       (fill_clear),
    .len_eff          (len_eff),
    .rank_lo          (rank_lo),
    .rank_hi          (rank_hi),
    .q_empty          (q_empty),
    .q_data           (q_rdata),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_trimmed_mean (out_trimmed_mean)
  );

endmodule

// File: sim/tb_winsorized_mean_engine.sv
// ----------------------------------------------------------------------------
// Winsorized mean engine testbench
// Streams sample vectors through the engine under several register settings,
// with random idling on both sides, and checks every mean against a model.
// ----------------------------------------------------------------------------
module tb_winsorized_mean_engine;
  import wme_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXL    = MAX_LEN_DEF;
  localparam int NO_WANT = 99999;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic signed [15:0]     in_sample = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic signed [OUT_W-1:0] out_trimmed_mean;

  winsorized_mean_engine dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_sample(in_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_trimmed_mean(out_trimmed_mean)
  );

  // Clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the register file and of the collected vector.
  logic [8:0]         sh_length = 9'd256;
  logic [7:0]         sh_low = 8'd0;
  logic [7:0]         sh_high = 8'd255;
  logic signed [15:0] sh_store [MAXL];
  int                 sh_fill = 0;

  logic signed [15:0] mean_queue [$];
  int  errors = 0;
  int  mismatches = 0;
  int  means_seen = 0;
  int  samples_sent = 0;
  bit  calm = 1'b0;
  bit  hold_off = 1'b0;

  // Winsorized mean of the first len collected samples.
  function automatic logic signed [15:0] winsorized_mean(int len);
    int      ranked [MAXL];
    int      r1, r2, j, v;
    longint  total, mag, quot;
    for (int i = 0; i < len; i++) begin
      v = sh_store[i];
      j = i;
      while (j > 0 && ranked[j-1] > v) begin
        ranked[j] = ranked[j-1];
        j--;
      end
      ranked[j] = v;
    end
    r1 = (sh_low >= len) ? len - 1 : sh_low;
    r2 = (sh_high >= len) ? len - 1 : sh_high;
    if (r2 < r1) r2 = r1;
    if (r1 == r2) return ranked[r1][15:0];
    total = longint'(r1 + 1) * ranked[r1] + longint'(len - r2) * ranked[r2];
    for (int i = r1 + 1; i < r2; i++) total += ranked[i];
    mag = (total < 0) ? -total : total;
    quot = (2 * mag + len) / (2 * len);
    if (total < 0) quot = -quot;
    return quot[15:0];
  endfunction

  // Track one accepted sample; a completed vector queues its mean.
  function automatic void collect_sample(logic signed [15:0] s);
    int len;
    len = (sh_length == 0) ? 1 : ((sh_length > MAXL) ? MAXL : int'(sh_length));
    if (sh_fill >= len) sh_fill = 0;
    sh_store[sh_fill] = s;
    sh_fill++;
    if (sh_fill >= len) begin
      sh_fill = 0;
      mean_queue.push_back(winsorized_mean(len));
    end
  endfunction

  // Now and then, drop valid for a random gap.
  task automatic maybe_idle();
    int n;
    if (!calm && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Offer one sample and wait until it is taken; valid drops on the next gap.
  task automatic send_sample(logic signed [15:0] s);
    maybe_idle();
    in_valid  <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    collect_sample(s);
    samples_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_VECTOR_LENGTH: begin
        sh_length = val;
        sh_fill = 0;
      end
      REG_LOW_RANK:  sh_low = val[7:0];
      REG_HIGH_RANK: sh_high = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Stop offering, let outstanding means drain, then let a partial vector settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (mean_queue.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic set_regs(int len, int lo, int hi);
    drain();
    write_reg(REG_VECTOR_LENGTH, len[8:0]);
    write_reg(REG_LOW_RANK, lo[8:0]);
    write_reg(REG_HIGH_RANK, hi[8:0]);
  endtask

  // Random sample with a bias towards the extremes and values near zero.
  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($signed($urandom_range(0, 8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  // Directed rows: length, low rank, high rank, fill value, expected or NO_WANT.
  typedef struct {
    int len;
    int lo;
    int hi;
    int fill;
    int want;
  } drow_t;

  drow_t dir_rows [11] = '{
    '{1,   0,   0,  32767, 32767},
    '{1,   0,   0, -32768, -32768},
    '{1,   5,   9,    -17,  -17},
    '{0,   0,   0,   1234,  1234},
    '{4,   1,   1,     -1,   -1},
    '{4,   3,   0,   -200, -200},
    '{256, 0, 255,  32767, 32767},
    '{2,   0,   1,     -1,   -1},
    '{3,   0,   2,     -1,   -1},
    '{5,   9,   9,      7,    7},
    '{511, 0, 255, -32768, -32768}
  };

  // Stimulus.
  initial begin
    int len, lo, hi;
    logic signed [15:0] s;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Constant vectors: winsorizing cannot move the mean, so it is typed in.
    foreach (dir_rows[r]) begin
      set_regs(dir_rows[r].len, dir_rows[r].lo, dir_rows[r].hi);
      len = (dir_rows[r].len == 0) ? 1 : ((dir_rows[r].len > MAXL) ? MAXL : dir_rows[r].len);
      for (int k = 0; k < len; k++) send_sample(16'(dir_rows[r].fill));
      if (dir_rows[r].want != NO_WANT && mean_queue.size() != 0)
        mean_queue[mean_queue.size() - 1] = 16'(dir_rows[r].want);
    end

    // Mixed vectors: rounding of halves, reversed ranks, mid-vector length write.
    set_regs(2, 0, 1);
    send_sample(16'sd1); send_sample(16'sd2);
    send_sample(-16'sd1); send_sample(-16'sd2);
    set_regs(6, 1, 4);
    send_sample(16'sh8000); send_sample(16'sh7fff); send_sample(16'sd5);
    send_sample(-16'sd9); send_sample(16'sd0); send_sample(16'sd33);
    set_regs(8, 6, 2);
    for (int k = 0; k < 8; k++) send_sample(rand_sample());
    send_sample(16'sd77);
    drain();
    write_reg(REG_VECTOR_LENGTH, 9'd3);
    for (int k = 0; k < 3; k++) send_sample(rand_sample());

    // Random phases, mostly short vectors; one full-length phase.
    for (int ph = 0; ph < 24; ph++) begin
      if (ph == 20) calm = 1'b1;
      len = (ph == 7) ? 256 : $urandom_range(1, 12);
      lo = $urandom_range(0, 15);
      hi = $urandom_range(0, 15);
      if (ph == 7) begin
        lo = 0;
        hi = 255;
      end
      if (ph == 9) begin
        lo = 255;
        hi = 255;
      end
      set_regs(len, lo, hi);
      if (ph == 5) hold_off = 1'b1;
      for (int k = 0; k < ((ph == 7) ? 256 : 20); k++) begin
        s = rand_sample();
        send_sample(s);
      end
    end

    drain();
    $display("Summary: %0d samples sent and %0d means checked over many lengths and ranks.",
             samples_sent, means_seen);
    if (errors == 0)
      $display("tb_winsorized_mean_engine passed");
    else
      $display("tb_winsorized_mean_engine failed");
    $finish;
  end

  // Result side stall: random bursts, plus one long hold-off on request.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        hold_off = 1'b0;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 8);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted mean with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      means_seen++;
      if (mean_queue.size() == 0) begin
        errors++;
        if (mismatches++ < 10)
          $display("Unexpected mean %0d", out_trimmed_mean);
      end else begin
        if (out_trimmed_mean !== mean_queue[0]) begin
          errors++;
          if (mismatches++ < 10)
            $display("Mean mismatch: expected %0d, actual %0d",
                     mean_queue[0], out_trimmed_mean);
        end
        void'(mean_queue.pop_front());
      end
    end
  end

  // Watchdog.
  initial begin
    #(12 * 1000000);
    $display("tb_winsorized_mean_engine failed");
    $finish;
  end

endmodule
